// ===== hdl/pubsub_packet_value_extractor_assert.svh =====
// Assertion macros for the packet value extractor checker.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef PUBSUB_PACKET_VALUE_EXTRACTOR_ASSERT_SVH
`define PUBSUB_PACKET_VALUE_EXTRACTOR_ASSERT_SVH

// Check cons in the same cycle as ante.
`define PVE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define PVE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pve_pkg.sv =====
// Shared types, constants and lookup functions for the packet value extractor.
// No dependencies; imported by every RTL module.
package pve_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int HL_BITS         = 32;
  localparam int WORD_BITS       = 32;
  localparam int HDR_BYTES       = 9;
  localparam int HL_BYTES        = 4;
  localparam int WORD_BYTES      = 4;
  localparam int MIN_MSG_LEN     = 4;
  localparam int NUM_STRINGS     = 4;
  localparam int KEY_STR_IDX     = 3;
  localparam int KEY_LEN         = 11;
  localparam int GAP_BYTES       = 24;
  localparam int Q_DEPTH         = 2;

  localparam int USR_VALUE_VALID = 0;
  localparam int USR_PACKET_DONE = 1;
  localparam int USR_MISMATCH    = 2;
  localparam int USR_MALFORMED   = 3;
  localparam int OUT_USER_W      = 4;

  typedef enum logic [3:0] {
    PH_HDR,
    PH_MLEN,
    PH_ID,
    PH_MTYPE,
    PH_DTYPE,
    PH_SLEN,
    PH_SBODY,
    PH_GAP,
    PH_VLEN,
    PH_VBODY,
    PH_SKIP,
    PH_DEAD
  } pve_phase_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_ARM,
    CMD_PARSE
  } pve_kind_t;

  typedef struct packed {
    logic [7:0] data;
    pve_kind_t  kind;
    logic       start;
    logic       last;
    logic       mismatch;
  } pve_cmd_t;

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "N";
      4'd1:    c = "O";
      4'd2:    c = "D";
      4'd3:    c = "E";
      4'd4:    c = "_";
      4'd5:    c = "R";
      4'd6:    c = "E";
      4'd7:    c = "P";
      4'd8:    c = "O";
      4'd9:    c = "R";
      4'd10:   c = "T";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_skip_type(input logic [7:0] b);
    logic hit;
    case (b) inside
      "R", "U", "*", "/", "~", "C", "A", ".", "i", "K", "W", "Q", 8'hFE, "T", "^":
        hit = 1'b1;
      default:
        hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== hdl/pve_front.sv =====
// Front end: accepts packet bytes, tracks position and header length,
// classifies each byte into a command for the parser. Uses pve_pkg.
module pve_front import pve_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] packet_start
  input  logic       in_tlast,
  input  logic       q_full,
  output logic       q_push,
  output pve_cmd_t   q_cmd
);

  localparam logic [LENGTH_BITS-1:0] POS_MAX = '1;

  logic [LENGTH_BITS-1:0] pos_r, pos_nxt, pos_cur, pos_inc;
  logic [HL_BITS-1:0]     hl_r, hl_nxt, hl_cur, hl_new;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    pos_cur = in_tuser ? '0 : pos_r;
    hl_cur  = in_tuser ? '0 : hl_r;
    hl_new  = hl_cur;
    if (pos_cur < LENGTH_BITS'(HL_BYTES)) begin
      hl_new = hl_cur | (HL_BITS'(in_tdata) << {pos_cur[1:0], 3'b000});
    end
    pos_inc = (pos_cur == POS_MAX) ? pos_cur : pos_cur + 1'b1;

    q_cmd.data     = in_tdata;
    q_cmd.start    = in_tuser;
    q_cmd.last     = in_tlast;
    q_cmd.mismatch = (hl_new != HL_BITS'(pos_inc));
    if (pos_cur < LENGTH_BITS'(HDR_BYTES - 1)) begin
      q_cmd.kind = CMD_NONE;
    end else if (pos_cur == LENGTH_BITS'(HDR_BYTES - 1)) begin
      q_cmd.kind = CMD_ARM;
    end else if (HL_BITS'(pos_cur) < hl_new) begin
      q_cmd.kind = CMD_PARSE;
    end else begin
      q_cmd.kind = CMD_NONE;
    end

    pos_nxt = pos_r;
    hl_nxt  = hl_r;
    if (q_push) begin
      pos_nxt = in_tlast ? '0 : pos_inc;
      hl_nxt  = in_tlast ? '0 : hl_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      hl_r  <= '0;
    end else begin
      pos_r <= pos_nxt;
      hl_r  <= hl_nxt;
    end
  end

endmodule

// ===== hdl/pve_queue.sv =====
// Short command queue between front end and parser, built from flops.
// Uses pve_pkg for the command type and depth.
module pve_queue import pve_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  pve_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output pve_cmd_t head_cmd
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  pve_cmd_t           mem_r [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (cnt_r == CNT_W'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/pve_back.sv =====
// Back end: message parser state machine and output register.
// Consumes commands from pve_queue; uses pve_pkg.
module pve_back import pve_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  pve_cmd_t              q_cmd,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [7:0] value_byte
  output logic [OUT_USER_W-1:0] out_tuser,  // [0] value_valid [1] packet_done
                                            // [2] length_mismatch [3] packet_malformed
  output logic                  out_tlast
);

  localparam logic [WORD_BITS-1:0] LEN_MAX = {WORD_BITS{1'b1}} >> (WORD_BITS - LENGTH_BITS);

  pve_phase_t             phase_r, phase_nxt;
  logic [WORD_BITS-1:0]   word_r, word_nxt, w_new;
  logic [LENGTH_BITS-1:0] msg_r, msg_nxt, fld_r, fld_nxt, fld_dec, w_sat;
  logic [2:0]             sidx_r, sidx_nxt;
  logic [3:0]             kpos_r, kpos_nxt;
  logic                   kmatch_r, kmatch_nxt, drop_r, drop_nxt, malf_r, malf_nxt;
  logic [1:0]             idx;
  logic                   emit, vlast, as_req, skip_req, malf_out, load;

  logic                   ov_r, ov_nxt;
  logic [7:0]             od_r;
  logic [OUT_USER_W-1:0]  ou_r;
  logic                   ol_r;

  assign q_pop      = q_valid && (!ov_r || out_tready);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

  always_comb begin
    phase_nxt  = phase_r;
    word_nxt   = word_r;
    msg_nxt    = msg_r;
    fld_nxt    = fld_r;
    sidx_nxt   = sidx_r;
    kpos_nxt   = kpos_r;
    kmatch_nxt = kmatch_r;
    drop_nxt   = drop_r;
    malf_nxt   = malf_r;
    emit       = 1'b0;
    vlast      = 1'b0;
    as_req     = 1'b0;
    skip_req   = 1'b0;
    idx        = '0;
    w_new      = '0;
    fld_dec    = '0;
    w_sat      = '0;
    malf_out   = 1'b0;

    if (q_pop) begin
      if (q_cmd.start) begin
        phase_nxt  = PH_HDR;
        word_nxt   = '0;
        msg_nxt    = '0;
        fld_nxt    = '0;
        sidx_nxt   = '0;
        kpos_nxt   = '0;
        kmatch_nxt = 1'b1;
        drop_nxt   = 1'b0;
        malf_nxt   = 1'b0;
      end

      idx     = 2'(2'd0 - fld_nxt[1:0]);
      w_new   = word_nxt | (WORD_BITS'(q_cmd.data) << {idx, 3'b000});
      fld_dec = fld_nxt - 1'b1;
      w_sat   = (w_new > LEN_MAX) ? LENGTH_BITS'(LEN_MAX) : LENGTH_BITS'(w_new);

      unique case (q_cmd.kind)
        CMD_ARM: begin
          phase_nxt = PH_MLEN;
          fld_nxt   = LENGTH_BITS'(WORD_BYTES);
          word_nxt  = '0;
        end
        CMD_PARSE: begin
          if (phase_nxt == PH_DEAD) begin
            phase_nxt = PH_DEAD;
          end else if (phase_nxt == PH_MLEN) begin
            word_nxt = w_new;
            fld_nxt  = fld_dec;
            if (fld_dec == '0) begin
              if (w_new[WORD_BITS-1] || w_new < WORD_BITS'(MIN_MSG_LEN)) begin
                malf_nxt  = 1'b1;
                phase_nxt = PH_DEAD;
              end else begin
                msg_nxt    = w_sat - LENGTH_BITS'(MIN_MSG_LEN);
                drop_nxt   = 1'b0;
                kmatch_nxt = 1'b1;
                sidx_nxt   = '0;
                phase_nxt  = PH_ID;
                fld_nxt    = LENGTH_BITS'(WORD_BYTES);
              end
            end
          end else if (phase_nxt == PH_SKIP) begin
            if (msg_nxt <= LENGTH_BITS'(1)) begin
              msg_nxt   = '0;
              phase_nxt = PH_MLEN;
              fld_nxt   = LENGTH_BITS'(WORD_BYTES);
              word_nxt  = '0;
            end else begin
              msg_nxt = msg_nxt - 1'b1;
            end
          end else if (msg_nxt == '0) begin
            malf_nxt  = 1'b1;
            phase_nxt = PH_DEAD;
          end else begin
            msg_nxt = msg_nxt - 1'b1;
            unique case (phase_nxt)
              PH_ID: begin
                fld_nxt = fld_dec;
                if (fld_dec == '0) phase_nxt = PH_MTYPE;
              end
              PH_MTYPE: begin
                if (is_skip_type(q_cmd.data)) drop_nxt = 1'b1;
                phase_nxt = PH_DTYPE;
              end
              PH_DTYPE: begin
                if (drop_nxt || q_cmd.data == "B" || q_cmd.data == "D") begin
                  drop_nxt = 1'b1;
                  skip_req = 1'b1;
                end else begin
                  sidx_nxt  = '0;
                  phase_nxt = PH_SLEN;
                  fld_nxt   = LENGTH_BITS'(WORD_BYTES);
                  word_nxt  = '0;
                end
              end
              PH_SLEN: begin
                word_nxt = w_new;
                fld_nxt  = fld_dec;
                if (fld_dec == '0) begin
                  if (w_new > WORD_BITS'(msg_nxt)) begin
                    malf_nxt  = 1'b1;
                    phase_nxt = PH_DEAD;
                  end else begin
                    if (sidx_nxt == 3'(KEY_STR_IDX)) begin
                      kpos_nxt   = '0;
                      kmatch_nxt = (w_new == WORD_BITS'(KEY_LEN));
                    end
                    fld_nxt = LENGTH_BITS'(w_new);
                    if (w_new == '0) as_req = 1'b1;
                    else phase_nxt = PH_SBODY;
                  end
                end
              end
              PH_SBODY: begin
                if (sidx_nxt == 3'(KEY_STR_IDX) && kmatch_nxt) begin
                  if (kpos_nxt < 4'(KEY_LEN) && q_cmd.data == key_char(kpos_nxt)) begin
                    kpos_nxt = kpos_nxt + 1'b1;
                  end else begin
                    kmatch_nxt = 1'b0;
                  end
                end
                fld_nxt = fld_dec;
                if (fld_dec == '0) as_req = 1'b1;
              end
              PH_GAP: begin
                fld_nxt = fld_dec;
                if (fld_dec == '0) begin
                  phase_nxt = PH_VLEN;
                  fld_nxt   = LENGTH_BITS'(WORD_BYTES);
                  word_nxt  = '0;
                end
              end
              PH_VLEN: begin
                word_nxt = w_new;
                fld_nxt  = fld_dec;
                if (fld_dec == '0) begin
                  if (w_new > WORD_BITS'(msg_nxt)) begin
                    malf_nxt  = 1'b1;
                    phase_nxt = PH_DEAD;
                  end else if (w_new == '0) begin
                    skip_req = 1'b1;
                  end else begin
                    fld_nxt   = LENGTH_BITS'(w_new);
                    phase_nxt = PH_VBODY;
                  end
                end
              end
              PH_VBODY: begin
                emit    = 1'b1;
                fld_nxt = fld_dec;
                if (fld_dec == '0) begin
                  vlast    = 1'b1;
                  skip_req = 1'b1;
                end
              end
              default: begin
                malf_nxt  = 1'b1;
                phase_nxt = PH_DEAD;
              end
            endcase

            // finish a string: next length word, skip, or value gap
            if (as_req) begin
              sidx_nxt = sidx_nxt + 1'b1;
              if (sidx_nxt < 3'(NUM_STRINGS)) begin
                phase_nxt = PH_SLEN;
                fld_nxt   = LENGTH_BITS'(WORD_BYTES);
                word_nxt  = '0;
              end else if (!kmatch_nxt) begin
                skip_req = 1'b1;
              end else begin
                phase_nxt = PH_GAP;
                fld_nxt   = LENGTH_BITS'(GAP_BYTES);
              end
            end
            if (skip_req) begin
              if (msg_nxt == '0) begin
                phase_nxt = PH_MLEN;
                fld_nxt   = LENGTH_BITS'(WORD_BYTES);
                word_nxt  = '0;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          end
        end
        default: begin
          phase_nxt = phase_nxt;
        end
      endcase

      malf_out = malf_nxt;
      if (q_cmd.last) begin
        phase_nxt  = PH_HDR;
        word_nxt   = '0;
        msg_nxt    = '0;
        fld_nxt    = '0;
        sidx_nxt   = '0;
        kpos_nxt   = '0;
        kmatch_nxt = 1'b1;
        drop_nxt   = 1'b0;
        malf_nxt   = 1'b0;
      end
    end
  end

  assign load   = q_pop && (emit || q_cmd.last);
  assign ov_nxt = load ? 1'b1 : (out_tready ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR;
      word_r   <= '0;
      msg_r    <= '0;
      fld_r    <= '0;
      sidx_r   <= '0;
      kpos_r   <= '0;
      kmatch_r <= 1'b1;
      drop_r   <= 1'b0;
      malf_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      word_r   <= word_nxt;
      msg_r    <= msg_nxt;
      fld_r    <= fld_nxt;
      sidx_r   <= sidx_nxt;
      kpos_r   <= kpos_nxt;
      kmatch_r <= kmatch_nxt;
      drop_r   <= drop_nxt;
      malf_r   <= malf_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      od_r                  <= emit ? q_cmd.data : 8'h00;
      ol_r                  <= vlast;
      ou_r[USR_VALUE_VALID] <= emit;
      ou_r[USR_PACKET_DONE] <= q_cmd.last;
      ou_r[USR_MISMATCH]    <= q_cmd.last && q_cmd.mismatch;
      ou_r[USR_MALFORMED]   <= q_cmd.last && malf_out;
    end
  end

endmodule

// ===== hdl/pubsub_packet_value_extractor.sv =====
// Top level of the packet value extractor: front end, command queue, parser.
// Depends on pve_pkg, pve_front, pve_queue and pve_back.
//
//   channel | dir | tdata          | tuser                               | tlast
//   in_     | in  | [7:0] data     | [0] packet_start                    | packet_end
//   out_    | out | [7:0] value    | [0] valid [1] done [2] mism [3] mal | value_last
//
// One byte per cycle sustained while out_tready is high; a result passes
// through the command queue and then the output register.
// Reset (rst_n low, synchronous) empties the queue and parser; no clearing pass.
// A stalled output holds the parser; the two-entry queue then fills and
// drops in_tready.
module pubsub_packet_value_extractor import pve_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tuser,   // [0] packet_start
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [7:0] value_byte
  output logic [OUT_USER_W-1:0] out_tuser,  // [0] value_valid [1] packet_done
                                            // [2] length_mismatch [3] packet_malformed
  output logic                  out_tlast
);

  pve_cmd_t push_cmd, head_cmd;
  logic     q_push, q_full, q_pop, head_valid;

  pve_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  pve_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  pve_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (head_valid),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hdl/pve_checker.sv =====
// Port-level checker for the packet value extractor, bound to the top level.
// Depends on pubsub_packet_value_extractor_assert.svh.
`include "pubsub_packet_value_extractor_assert.svh"

module pve_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [3:0] out_tuser,
  input logic       out_tlast
);

  `PVE_ASSERT_NOW(a_item_not_empty, out_tvalid, out_tuser[0] || out_tuser[1], "empty result item")
  `PVE_ASSERT_NOW(a_flags_need_done, out_tvalid && (out_tuser[2] || out_tuser[3]), out_tuser[1], "status flag without packet_done")
  `PVE_ASSERT_NOW(a_no_value_clear, out_tvalid && !out_tuser[0], out_tdata == 8'h00 && !out_tlast, "value fields set without value_valid")
  `PVE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled item changed")

endmodule

bind pubsub_packet_value_extractor pve_checker u_pve_checker (.*);
